// File: rtl/feg_pkg.sv
`default_nettype none

package feg_pkg;

    localparam int FRAME_BITS_DEF     = 32;
    localparam int GAIN_FRAC_BITS_DEF = 16;
    localparam int CFG_INDEX_BITS     = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_TRACK_LENGTH    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FADE_IN_LENGTH  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FADE_OUT_LENGTH = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TRIM_GAIN       = 2'd3;

    typedef struct packed {
        logic zero;
        logic use_in;
        logic use_out;
    } feg_ctl_t;

endpackage

`default_nettype wire

// File: rtl/feg_front.sv
`default_nettype none

module feg_front #(
    parameter int FRAME_BITS = feg_pkg::FRAME_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [FRAME_BITS-1:0] track_length,
    input  logic [FRAME_BITS-2:0] fade_in_length,
    input  logic [FRAME_BITS-2:0] fade_out_length,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  logic [FRAME_BITS-1:0] frame_index,
    output logic                  dn_valid,
    input  logic                  dn_ready,
    output feg_pkg::feg_ctl_t     dn_ctl,
    output logic [FRAME_BITS-1:0] dn_rem_in,
    output logic [FRAME_BITS-1:0] dn_rem_out
);
    import feg_pkg::*;

    logic                  valid_reg;
    feg_ctl_t              ctl_reg;
    feg_ctl_t              ctl_next;
    logic [FRAME_BITS-1:0] rem_in_reg;
    logic [FRAME_BITS-1:0] rem_out_reg;
    logic [FRAME_BITS-1:0] fi_ext;
    logic [FRAME_BITS-1:0] fo_ext;
    logic [FRAME_BITS-1:0] start;
    logic [FRAME_BITS-1:0] remain;
    logic                  load;

    assign fi_ext = {1'b0, fade_in_length};
    assign fo_ext = {1'b0, fade_out_length};
    assign start  = (fo_ext > track_length) ? '0 : track_length - fo_ext;
    assign remain = track_length - frame_index;

    always_comb
    begin
        ctl_next.zero    = frame_index >= track_length;
        ctl_next.use_in  = (fade_in_length != '0) && (frame_index < fi_ext);
        ctl_next.use_out = (fade_out_length != '0) && (frame_index >= start)
                           && (remain < fo_ext) && !ctl_next.zero;
    end

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctl_reg     <= ctl_next;
            rem_in_reg  <= frame_index;
            rem_out_reg <= remain;
        end
    end

    assign dn_valid   = valid_reg;
    assign dn_ctl     = ctl_reg;
    assign dn_rem_in  = rem_in_reg;
    assign dn_rem_out = rem_out_reg;

endmodule

`default_nettype wire

// File: rtl/feg_cell.sv
`default_nettype none

module feg_cell #(
    parameter int FRAME_BITS     = feg_pkg::FRAME_BITS_DEF,
    parameter int GAIN_FRAC_BITS = feg_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [FRAME_BITS-2:0]     fade_in_length,
    input  logic [FRAME_BITS-2:0]     fade_out_length,
    input  logic                      up_valid,
    output logic                      up_ready,
    input  feg_pkg::feg_ctl_t         up_ctl,
    input  logic [FRAME_BITS-1:0]     up_rem_in,
    input  logic [FRAME_BITS-1:0]     up_rem_out,
    input  logic [GAIN_FRAC_BITS-1:0] up_q_in,
    input  logic [GAIN_FRAC_BITS-1:0] up_q_out,
    output logic                      dn_valid,
    input  logic                      dn_ready,
    output feg_pkg::feg_ctl_t         dn_ctl,
    output logic [FRAME_BITS-1:0]     dn_rem_in,
    output logic [FRAME_BITS-1:0]     dn_rem_out,
    output logic [GAIN_FRAC_BITS-1:0] dn_q_in,
    output logic [GAIN_FRAC_BITS-1:0] dn_q_out
);
    import feg_pkg::*;

    logic                      valid_reg;
    feg_ctl_t                  ctl_reg;
    logic [FRAME_BITS-1:0]     rem_in_reg;
    logic [FRAME_BITS-1:0]     rem_out_reg;
    logic [GAIN_FRAC_BITS-1:0] q_in_reg;
    logic [GAIN_FRAC_BITS-1:0] q_out_reg;
    logic [FRAME_BITS-1:0]     den_in;
    logic [FRAME_BITS-1:0]     den_out;
    logic [FRAME_BITS-1:0]     sh_in;
    logic [FRAME_BITS-1:0]     sh_out;
    logic                      ge_in;
    logic                      ge_out;
    logic [FRAME_BITS-1:0]     rem_in_next;
    logic [FRAME_BITS-1:0]     rem_out_next;
    logic [GAIN_FRAC_BITS-1:0] q_in_next;
    logic [GAIN_FRAC_BITS-1:0] q_out_next;
    logic                      load;

    assign den_in  = {1'b0, fade_in_length};
    assign den_out = {1'b0, fade_out_length};

    // restoring step: one quotient bit for each lane
    assign sh_in  = {up_rem_in[FRAME_BITS-2:0], 1'b0};
    assign sh_out = {up_rem_out[FRAME_BITS-2:0], 1'b0};
    assign ge_in  = sh_in >= den_in;
    assign ge_out = sh_out >= den_out;

    assign rem_in_next  = ge_in ? sh_in - den_in : sh_in;
    assign rem_out_next = ge_out ? sh_out - den_out : sh_out;
    assign q_in_next    = {up_q_in[GAIN_FRAC_BITS-2:0], ge_in};
    assign q_out_next   = {up_q_out[GAIN_FRAC_BITS-2:0], ge_out};

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctl_reg     <= up_ctl;
            rem_in_reg  <= rem_in_next;
            rem_out_reg <= rem_out_next;
            q_in_reg    <= q_in_next;
            q_out_reg   <= q_out_next;
        end
    end

    assign dn_valid   = valid_reg;
    assign dn_ctl     = ctl_reg;
    assign dn_rem_in  = rem_in_reg;
    assign dn_rem_out = rem_out_reg;
    assign dn_q_in    = q_in_reg;
    assign dn_q_out   = q_out_reg;

endmodule

`default_nettype wire

// File: rtl/feg_out.sv
`default_nettype none

module feg_out #(
    parameter int GAIN_FRAC_BITS = feg_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [GAIN_FRAC_BITS+1:0] trim_gain,
    input  logic                      up_valid,
    output logic                      up_ready,
    input  feg_pkg::feg_ctl_t         up_ctl,
    input  logic [GAIN_FRAC_BITS-1:0] up_q_in,
    input  logic [GAIN_FRAC_BITS-1:0] up_q_out,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [GAIN_FRAC_BITS+1:0] frame_gain
);
    import feg_pkg::*;

    localparam logic [GAIN_FRAC_BITS:0] UNITY = (GAIN_FRAC_BITS+1)'(1) << GAIN_FRAC_BITS;

    logic                        valid_reg;
    logic [GAIN_FRAC_BITS+1:0]   gain_reg;
    logic [GAIN_FRAC_BITS+1:0]   gain_next;
    logic [GAIN_FRAC_BITS:0]     env_in;
    logic [GAIN_FRAC_BITS:0]     env_out;
    logic [GAIN_FRAC_BITS:0]     env;
    logic [2*GAIN_FRAC_BITS+2:0] prod;
    feg_ctl_t                    ctl;

    assign ctl     = up_ctl;
    assign env_in  = ctl.use_in ? {1'b0, up_q_in} : UNITY;
    assign env_out = ctl.use_out ? {1'b0, up_q_out} : UNITY;
    assign env     = (env_out < env_in) ? env_out : env_in;
    assign prod    = env * trim_gain;

    assign gain_next = ctl.zero ? '0 : prod[GAIN_FRAC_BITS +: GAIN_FRAC_BITS+2];

    assign up_ready = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            gain_reg <= gain_next;
        end
    end

    assign out_valid  = valid_reg;
    assign frame_gain = gain_reg;

endmodule

`default_nettype wire

// File: rtl/fade_envelope_gain.sv
// Per-frame gain of one track: linear fade-in and fade-out envelope times a
// trim gain, unsigned Q2.GAIN_FRAC_BITS, zero at or past the track length.
// One frame index is taken every clock while in_stall is low. A request
// goes through one stage that classifies the frame, a row of GAIN_FRAC_BITS
// cells that each produce one quotient bit of both fade ratios, and a stage
// that takes the smaller ratio and scales it by the trim gain. Every stage
// holds its own request, so the row keeps filling while a result waits at
// the output. Write the registers only while no request is in flight.
`default_nettype none

module fade_envelope_gain #(
    parameter int FRAME_BITS     = feg_pkg::FRAME_BITS_DEF,
    parameter int GAIN_FRAC_BITS = feg_pkg::GAIN_FRAC_BITS_DEF,
    localparam int CFG_DATA_BITS = (FRAME_BITS > GAIN_FRAC_BITS + 2) ?
                                   FRAME_BITS : GAIN_FRAC_BITS + 2
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [feg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]           cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [FRAME_BITS-1:0]              frame_index,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [GAIN_FRAC_BITS+1:0]          frame_gain
);
    import feg_pkg::*;

    localparam int NCELL = GAIN_FRAC_BITS;

    logic [FRAME_BITS-1:0]     track_length_reg;
    logic [FRAME_BITS-2:0]     fade_in_length_reg;
    logic [FRAME_BITS-2:0]     fade_out_length_reg;
    logic [GAIN_FRAC_BITS+1:0] trim_gain_reg;

    logic                      c_valid   [0:NCELL];
    logic                      c_ready   [0:NCELL];
    feg_ctl_t                  c_ctl     [0:NCELL];
    logic [FRAME_BITS-1:0]     c_rem_in  [0:NCELL];
    logic [FRAME_BITS-1:0]     c_rem_out [0:NCELL];
    logic [GAIN_FRAC_BITS-1:0] c_q_in    [0:NCELL];
    logic [GAIN_FRAC_BITS-1:0] c_q_out   [0:NCELL];
    logic                      front_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_length_reg    <= '0;
            fade_in_length_reg  <= '0;
            fade_out_length_reg <= '0;
            trim_gain_reg       <= (GAIN_FRAC_BITS+2)'(1) << GAIN_FRAC_BITS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TRACK_LENGTH:
                begin
                    track_length_reg <= cfg_data[FRAME_BITS-1:0];
                end
                REG_FADE_IN_LENGTH:
                begin
                    fade_in_length_reg <= cfg_data[FRAME_BITS-2:0];
                end
                REG_FADE_OUT_LENGTH:
                begin
                    fade_out_length_reg <= cfg_data[FRAME_BITS-2:0];
                end
                REG_TRIM_GAIN:
                begin
                    trim_gain_reg <= cfg_data[GAIN_FRAC_BITS+1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    feg_front #(
        .FRAME_BITS(FRAME_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .track_length   (track_length_reg),
        .fade_in_length (fade_in_length_reg),
        .fade_out_length(fade_out_length_reg),
        .up_valid       (in_valid),
        .up_ready       (front_ready),
        .frame_index    (frame_index),
        .dn_valid       (c_valid[0]),
        .dn_ready       (c_ready[0]),
        .dn_ctl         (c_ctl[0]),
        .dn_rem_in      (c_rem_in[0]),
        .dn_rem_out     (c_rem_out[0])
    );

    assign in_stall   = !front_ready;
    assign c_q_in[0]  = '0;
    assign c_q_out[0] = '0;

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        feg_cell #(
            .FRAME_BITS    (FRAME_BITS),
            .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .fade_in_length (fade_in_length_reg),
            .fade_out_length(fade_out_length_reg),
            .up_valid       (c_valid[i]),
            .up_ready       (c_ready[i]),
            .up_ctl         (c_ctl[i]),
            .up_rem_in      (c_rem_in[i]),
            .up_rem_out     (c_rem_out[i]),
            .up_q_in        (c_q_in[i]),
            .up_q_out       (c_q_out[i]),
            .dn_valid       (c_valid[i+1]),
            .dn_ready       (c_ready[i+1]),
            .dn_ctl         (c_ctl[i+1]),
            .dn_rem_in      (c_rem_in[i+1]),
            .dn_rem_out     (c_rem_out[i+1]),
            .dn_q_in        (c_q_in[i+1]),
            .dn_q_out       (c_q_out[i+1])
        );
    end

    feg_out #(
        .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .trim_gain (trim_gain_reg),
        .up_valid  (c_valid[NCELL]),
        .up_ready  (c_ready[NCELL]),
        .up_ctl    (c_ctl[NCELL]),
        .up_q_in   (c_q_in[NCELL]),
        .up_q_out  (c_q_out[NCELL]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .frame_gain(frame_gain)
    );

endmodule

`default_nettype wire

// File: rtl/feg_checker.sv
`default_nettype none

module feg_checker #(
    parameter int FRAME_BITS     = feg_pkg::FRAME_BITS_DEF,
    parameter int GAIN_FRAC_BITS = feg_pkg::GAIN_FRAC_BITS_DEF,
    localparam int CFG_DATA_BITS = (FRAME_BITS > GAIN_FRAC_BITS + 2) ?
                                   FRAME_BITS : GAIN_FRAC_BITS + 2
) (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               cfg_valid,
    input wire logic                               cfg_ready,
    input wire logic [feg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input wire logic [CFG_DATA_BITS-1:0]           cfg_data,
    input wire logic                               in_valid,
    input wire logic                               in_stall,
    input wire logic [FRAME_BITS-1:0]              frame_index,
    input wire logic                               out_valid,
    input wire logic                               out_stall,
    input wire logic [GAIN_FRAC_BITS+1:0]          frame_gain
);
    import feg_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(frame_gain))
        else $error("stalled result changed or dropped");

    // back-pressure only when the output is full and held
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output free");

    // take register writes at once
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("register write refused");

    // a free output never holds back a request
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && in_valid |-> !in_stall)
        else $error("request stalled with empty output");

endmodule

bind fade_envelope_gain feg_checker #(
    .FRAME_BITS    (FRAME_BITS),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
) u_feg_checker (.*);

`default_nettype wire
